// ===== rtl/core/rwtc_pkg.sv =====
package rwtc_pkg;

	// Operation codes carried on the input tuser
	localparam logic OP_SETUP = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Texture select codes
	localparam logic [1:0] TEX_EAST  = 2'd0;
	localparam logic [1:0] TEX_WEST  = 2'd1;
	localparam logic [1:0] TEX_SOUTH = 2'd2;
	localparam logic [1:0] TEX_NORTH = 2'd3;

	// Default texture edge length, a power of two
	localparam int TEX_SIZE_DEF = 64;

	// Field and state widths
	localparam int COL_W    = 12;
	localparam int ROW_W    = 13;
	localparam int POS_IN_W = 24;
	localparam int DIR_W    = 18;
	localparam int DIST_W   = 24;
	localparam int LH_W     = 16;
	localparam int SPAN_W   = 12;
	localparam int SCR_W    = 12;
	localparam int TEXEL_W  = 6;
	localparam int STEP_W   = 24;
	localparam int TPOS_W   = 40;
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 40;

	localparam logic [SCR_W-1:0] SCREEN_H_RST = 12'd480;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic hit_mul;
		logic div_start;
		logic pos_mul;
		logic commit;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic row_left;
		logic div_busy;
	} status_t;

endpackage

// ===== rtl/core/rwtc_div.sv =====
module rwtc_div
	import rwtc_pkg::*;
#(
	parameter int TEX_LOG = 6,
	parameter int NUM_W   = TEX_LOG + 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LH_W-1:0]  den,
	output logic [NUM_W-1:0] quotient,
	output logic             busy
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [NUM_W-1:0] NUMER = NUM_W'(1) << (TEX_LOG + 16);

	logic [LH_W-1:0]  rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [LH_W:0]    trial;
	logic [LH_W:0]    diff;
	logic             ge;

	// Restoring step: shift in one numerator bit, subtract when it fits
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= NUMER;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LH_W-1:0] : trial[LH_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == CNT_W'(NUM_W))
		else $error("divider did not start");
`endif

endmodule

// ===== rtl/core/rwtc_dp.sv =====
module rwtc_dp
	import rwtc_pkg::*;
#(
	parameter int TEX_SIZE = TEX_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [SCR_W-1:0]           cfg_wdata,
	input  logic [COL_W-1:0]           column,
	input  logic                       hit_side,
	input  logic [POS_IN_W-1:0]        player_x,
	input  logic [POS_IN_W-1:0]        player_y,
	input  logic signed [DIR_W-1:0]    dir_x,
	input  logic signed [DIR_W-1:0]    dir_y,
	input  logic [DIST_W-1:0]          wall_distance,
	input  logic [LH_W-1:0]            line_height,
	input  logic [SPAN_W-1:0]          span_start,
	input  logic [ROW_W-1:0]           span_end,
	input  cmd_t                       cmd,
	output status_t                    status,
	output logic [COL_W-1:0]           out_column,
	output logic [SPAN_W-1:0]          out_row,
	output logic [1:0]                 texture_id,
	output logic [TEXEL_W-1:0]         texel_x,
	output logic [TEXEL_W-1:0]         texel_y,
	output logic                       last_row
);

	localparam int TEX_LOG = $clog2(TEX_SIZE);
	localparam int TX_W    = (TEX_LOG > TEXEL_W) ? TEX_LOG : TEXEL_W;
	localparam int NUM_W   = TEX_LOG + 17;
	localparam int NUMR_W  = 18;
	localparam int PROD_W  = NUMR_W + STEP_W + 1;

	// Configuration
	logic [SCR_W-1:0] screen_height_q;

	// Captured setup item
	logic [COL_W-1:0]        col_set_q;
	logic                    side_q;
	logic                    dx_pos_q;
	logic                    dx_neg_q;
	logic                    dy_pos_q;
	logic                    dy_neg_q;
	logic [15:0]             p_lo_q;
	logic signed [DIR_W-1:0] d_q;
	logic [DIST_W-1:0]       dist_q;
	logic [LH_W-1:0]         lh_q;
	logic [SPAN_W-1:0]       start_q;
	logic [ROW_W-1:0]        end_q;

	// Setup intermediates
	logic [31:0]         mul_q;
	logic [TPOS_W-1:0]   prod_q;
	logic [STEP_W-1:0]   step_set_q;

	// Column state
	logic [COL_W-1:0]    cur_column_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ROW_W-1:0]    end_row_q;
	logic [1:0]          tex_select_q;
	logic [TEXEL_W-1:0]  tex_column_q;
	logic [TPOS_W-1:0]   tex_position_q;
	logic [STEP_W-1:0]   tex_step_q;

	logic signed [DIST_W+DIR_W:0] hit_prod;
	logic [NUM_W-1:0]             quotient;
	logic                         div_busy;
	logic [STEP_W-1:0]            step_sat;
	logic signed [NUMR_W-1:0]     numr;
	logic signed [PROD_W-1:0]     pos_prod;
	logic [31:0]                  hit;
	logic [TEX_LOG-1:0]           tx_raw;
	logic [TEX_LOG-1:0]           tx_mir;
	logic [TX_W-1:0]              tx_ext;
	logic [TX_W-1:0]              ty_ext;
	logic                         mirror;
	logic [1:0]                   sel;
	logic [ROW_W:0]               row_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= SCREEN_H_RST;
		end else if (cfg_we) begin
			screen_height_q <= cfg_wdata;
		end
	end

	// Capture the setup item, choosing the coordinate along the wall
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_set_q <= column;
			side_q    <= hit_side;
			dx_pos_q  <= !dir_x[DIR_W-1] && (dir_x != '0);
			dx_neg_q  <= dir_x[DIR_W-1];
			dy_pos_q  <= !dir_y[DIR_W-1] && (dir_y != '0);
			dy_neg_q  <= dir_y[DIR_W-1];
			p_lo_q    <= hit_side ? player_x[15:0] : player_y[15:0];
			d_q       <= hit_side ? dir_x : dir_y;
			dist_q    <= wall_distance;
			lh_q      <= (line_height == '0) ? LH_W'(1) : line_height;
			start_q   <= span_start;
			end_q     <= span_end;
		end
	end

	// Distance times direction, low 32 bits are all the fraction needs
	assign hit_prod = $signed({1'b0, dist_q}) * d_q;

	always_ff @(posedge clk) begin
		if (cmd.hit_mul) begin
			mul_q <= hit_prod[31:0];
		end
	end

	rwtc_div #(
		.TEX_LOG (TEX_LOG),
		.NUM_W   (NUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.den      (lh_q),
		.quotient (quotient),
		.busy     (div_busy)
	);

	// Saturate the step to its register width
	generate
		if (NUM_W > STEP_W) begin : g_sat
			assign step_sat = (|quotient[NUM_W-1:STEP_W]) ? '1 : quotient[STEP_W-1:0];
		end else begin : g_nosat
			assign step_sat = STEP_W'(quotient);
		end
	endgenerate

	// Starting texture position: (2*start - H + lh) * step / 2, floored
	assign numr = $signed({5'b0, start_q, 1'b0}) - $signed({6'b0, screen_height_q})
		+ $signed({2'b0, lh_q});
	assign pos_prod = numr * $signed({1'b0, step_sat});

	always_ff @(posedge clk) begin
		if (cmd.pos_mul) begin
			prod_q     <= pos_prod[TPOS_W:1];
			step_set_q <= step_sat;
		end
	end

	// Texture column from the hit fraction, mirrored by side and direction
	assign hit    = {p_lo_q, 16'b0} + mul_q;
	assign tx_raw = hit[31 -: TEX_LOG];
	assign mirror = (!side_q && dx_pos_q) || (side_q && dy_neg_q);
	assign tx_mir = mirror ? ~tx_raw : tx_raw;
	assign tx_ext = TX_W'(tx_mir);

	always_comb begin
		priority if (!side_q && dx_pos_q) begin
			sel = TEX_EAST;
		end else if (!side_q && dx_neg_q) begin
			sel = TEX_WEST;
		end else if (side_q && dy_pos_q) begin
			sel = TEX_SOUTH;
		end else begin
			sel = TEX_NORTH;
		end
	end

	assign ty_ext  = TX_W'(tex_position_q[16 +: TEX_LOG]);
	assign row_inc = {1'b0, cur_row_q} + (ROW_W+1)'(1);

	// Column state: load on commit, advance one row per emitted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_column_q   <= '0;
			cur_row_q      <= '0;
			end_row_q      <= '0;
			tex_select_q   <= '0;
			tex_column_q   <= '0;
			tex_position_q <= '0;
			tex_step_q     <= '0;
		end else if (cmd.commit) begin
			cur_column_q   <= col_set_q;
			cur_row_q      <= {1'b0, start_q};
			end_row_q      <= end_q;
			tex_select_q   <= sel;
			tex_column_q   <= tx_ext[TEXEL_W-1:0];
			tex_position_q <= prod_q;
			tex_step_q     <= step_set_q;
		end else if (cmd.emit) begin
			cur_row_q      <= row_inc[ROW_W-1:0];
			tex_position_q <= tex_position_q + {{(TPOS_W-STEP_W){1'b0}}, tex_step_q};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_column <= cur_column_q;
			out_row    <= cur_row_q[SPAN_W-1:0];
			texture_id <= tex_select_q;
			texel_x    <= tex_column_q;
			texel_y    <= ty_ext[TEXEL_W-1:0];
			last_row   <= row_inc >= {1'b0, end_row_q};
		end
	end

	assign status.row_left = cur_row_q < end_row_q;
	assign status.div_busy = div_busy;

`ifndef SYNTHESIS
	a_emit_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_row == $past(cur_row_q[SPAN_W-1:0]))
		else $error("emitted row does not match current row");
`endif

endmodule

// ===== rtl/core/rwtc_ctrl.sv =====
module rwtc_ctrl
	import rwtc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    operation,
	input  logic    m_tready,
	input  status_t status,
	output logic    s_tready,
	output logic    m_tvalid,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT,
		ST_DIV,
		ST_POS,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   accept;

	// Take items only when idle and the output register can be refilled
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd.load      = accept && (operation == OP_SETUP);
		cmd.emit      = accept && (operation == OP_PIXEL) && status.row_left;
		cmd.hit_mul   = state_q == ST_HIT;
		cmd.div_start = state_q == ST_HIT;
		cmd.pos_mul   = state_q == ST_POS;
		cmd.commit    = state_q == ST_COMMIT;
	end

	// Sequence the column setup; hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_HIT;
					end
				end
				ST_HIT: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!status.div_busy) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken during column setup");
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("stalled result dropped");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |=> (state_q == ST_IDLE))
		else $error("setup did not finish after commit");
`endif

endmodule

// ===== rtl/core/raycast_wall_texture_column.sv =====
// Textured wall column stepper for a grid raycaster.
// Input stream (s_*): one transaction per item. s_tuser selects the operation:
// setup of a new screen column, or emit of the next pixel row. Setup carries
// the ray hit and the clipped draw span and produces no output.
// Output stream (m_*): one transaction per pixel row with its screen position,
// texture select and texel coordinates; m_tlast marks the final row of a span.
// A pixel item with no rows left produces nothing.
// Throughput: pixel items are taken one per cycle while no setup is in progress
// and the output register can be refilled; a result appears in the cycle after
// its item is accepted and sits in that output register. A setup item holds off
// input until done; the bit-serial divider forms TEX_SIZE * 65536 / line height.
// While the receiver stalls, the held result stays put and input is taken
// only once that register is freed in the same cycle.
// cfg_we/cfg_wdata write the screen height; write it only while idle.
// Reset clears the column state (so pixel items emit nothing until a setup),
// drops any pending result and sets the screen height to 480.
module raycast_wall_texture_column
	import rwtc_pkg::*;
#(
	parameter int TEX_SIZE = TEX_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [SCR_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// column, hit_side, player_x, player_y, dir_x, dir_y, wall_distance,
	// line_height, span_start, span_end, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_column, out_row, texture_id, texel_x, texel_y, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	cmd_t    cmd;
	status_t status;

	logic [COL_W-1:0]   out_column;
	logic [SPAN_W-1:0]  out_row;
	logic [1:0]         texture_id;
	logic [TEXEL_W-1:0] texel_x;
	logic [TEXEL_W-1:0] texel_y;

	rwtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.operation (s_tuser),
		.m_tready  (m_tready),
		.status    (status),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.cmd       (cmd)
	);

	rwtc_dp #(
		.TEX_SIZE (TEX_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.column        (s_tdata[11:0]),
		.hit_side      (s_tdata[12]),
		.player_x      (s_tdata[36:13]),
		.player_y      (s_tdata[60:37]),
		.dir_x         ($signed(s_tdata[78:61])),
		.dir_y         ($signed(s_tdata[96:79])),
		.wall_distance (s_tdata[120:97]),
		.line_height   (s_tdata[136:121]),
		.span_start    (s_tdata[148:137]),
		.span_end      (s_tdata[161:149]),
		.cmd           (cmd),
		.status        (status),
		.out_column    (out_column),
		.out_row       (out_row),
		.texture_id    (texture_id),
		.texel_x       (texel_x),
		.texel_y       (texel_y),
		.last_row      (m_tlast)
	);

	assign m_tdata = {2'b0, texel_y, texel_x, texture_id, out_row, out_column};

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import rwtc_pkg::*;

	// Input transaction layout, first field in the lowest bits
	typedef struct packed {
		logic [5:0]        pad;
		logic [ROW_W-1:0]  span_end;
		logic [SPAN_W-1:0] span_start;
		logic [LH_W-1:0]   line_height;
		logic [DIST_W-1:0] wall_distance;
		logic [DIR_W-1:0]  dir_y;
		logic [DIR_W-1:0]  dir_x;
		logic [POS_IN_W-1:0] player_y;
		logic [POS_IN_W-1:0] player_x;
		logic              hit_side;
		logic [COL_W-1:0]  column;
	} ray_hit_t;

	// Output transaction layout, first field in the lowest bits
	typedef struct packed {
		logic [1:0]         pad;
		logic [TEXEL_W-1:0] texel_y;
		logic [TEXEL_W-1:0] texel_x;
		logic [1:0]         texture_id;
		logic [11:0]        out_row;
		logic [COL_W-1:0]   out_column;
	} texel_out_t;

	typedef struct {
		texel_out_t pix;
		logic       last_row;
	} texel_due_t;

	// Tracks the column stepper state and the texels still owed by the block
	class column_texel_tracker;
		logic [SCR_W-1:0]   height;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [ROW_W-1:0]   end_row;
		logic [1:0]         tex_sel;
		logic [TEXEL_W-1:0] tex_col;
		logic [TPOS_W-1:0]  tpos;
		logic [STEP_W-1:0]  tstep;
		texel_due_t         texels_due[$];
		int                 errors;

		function new();
			height  = SCREEN_H_RST;
			col     = '0;
			row     = '0;
			end_row = '0;
			tex_sel = TEX_EAST;
			tex_col = '0;
			tpos    = '0;
			tstep   = '0;
			errors  = 0;
		endfunction

		function void set_height(logic [SCR_W-1:0] h);
			height = h;
		endfunction

		function int outstanding();
			return texels_due.size();
		endfunction

		// Note an accepted input transaction; return 1 if it did anything
		function bit take_item(logic op, logic [IN_DATA_W-1:0] data);
			ray_hit_t   h;
			longint     p, d, dx, dy, wdist, lh, st, num, prod;
			logic [63:0] hitv;
			logic [TEXEL_W-1:0] tx;
			texel_due_t e;
			h = data;
			if (op == OP_SETUP) begin
				dx    = longint'($signed(h.dir_x));
				dy    = longint'($signed(h.dir_y));
				p     = h.hit_side ? longint'(h.player_x) : longint'(h.player_y);
				d     = h.hit_side ? dx : dy;
				wdist = longint'(h.wall_distance);
				hitv  = (p <<< 16) + wdist * d;
				tx    = hitv[31:26];
				// mirror the column on the far-facing walls
				if ((!h.hit_side && dx > 0) || (h.hit_side && dy < 0))
					tx = 6'd63 - tx;
				if (!h.hit_side && dx > 0)
					tex_sel = TEX_EAST;
				else if (!h.hit_side && dx < 0)
					tex_sel = TEX_WEST;
				else if (h.hit_side && dy > 0)
					tex_sel = TEX_SOUTH;
				else
					tex_sel = TEX_NORTH;
				lh = (h.line_height == 0) ? longint'(1) : longint'(h.line_height);
				st = (longint'(64) <<< 16) / lh;
				if (st > longint'(24'hFFFFFF))
					st = longint'(24'hFFFFFF);
				num  = 2 * longint'(h.span_start) - longint'(height) + lh;
				prod = (num * st) >>> 1;
				tex_col = tx;
				tstep   = st[STEP_W-1:0];
				tpos    = prod[TPOS_W-1:0];
				col     = h.column;
				row     = {1'b0, h.span_start};
				end_row = h.span_end;
				return 1'b1;
			end
			// pixel item: emit one row while the span lasts
			if (row >= end_row)
				return 1'b0;
			e.pix            = '0;
			e.pix.out_column = col;
			e.pix.out_row    = row[11:0];
			e.pix.texture_id = tex_sel;
			e.pix.texel_x    = tex_col;
			e.pix.texel_y    = tpos[21:16];
			e.last_row       = (({1'b0, row} + 14'd1) >= {1'b0, end_row});
			texels_due.push_back(e);
			tpos = tpos + TPOS_W'(tstep);
			row  = row + ROW_W'(1);
			return 1'b1;
		endfunction

		function void cmp_field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Check one output transaction against the oldest owed texel
		function void match_texel(logic [OUT_DATA_W-1:0] data, logic last);
			texel_out_t got;
			texel_due_t want;
			got = data;
			if (texels_due.size() == 0) begin
				$error("unexpected output transaction: tdata %h tlast %b", data, last);
				errors++;
				return;
			end
			want = texels_due.pop_front();
			cmp_field("out_column", longint'(want.pix.out_column), longint'(got.out_column));
			cmp_field("out_row", longint'(want.pix.out_row), longint'(got.out_row));
			cmp_field("texture_id", longint'(want.pix.texture_id), longint'(got.texture_id));
			cmp_field("texel_x", longint'(want.pix.texel_x), longint'(got.texel_x));
			cmp_field("texel_y", longint'(want.pix.texel_y), longint'(got.texel_y));
			cmp_field("last_row", longint'(want.last_row), longint'(last));
			cmp_field("pad", longint'(0), longint'(got.pad));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [SCR_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int send_idle = 18;
	int recv_idle = 71;
	int live_items;

	column_texel_tracker tracker = new();

	raycast_wall_texture_column dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stall the receiver at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Check every output transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_texel(m_tdata, m_tlast);
	end

	function automatic logic [IN_DATA_W-1:0] noise_bits();
		logic [191:0] w;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return w[IN_DATA_W-1:0];
	endfunction

	function automatic ray_hit_t make_hit(int column, int side, int px, int py, int dx, int dy,
			int wdist, int lh, int s, int e);
		ray_hit_t h;
		h               = '0;
		h.column        = COL_W'(column);
		h.hit_side      = side[0];
		h.player_x      = POS_IN_W'(px);
		h.player_y      = POS_IN_W'(py);
		h.dir_x         = DIR_W'(dx);
		h.dir_y         = DIR_W'(dy);
		h.wall_distance = DIST_W'(wdist);
		h.line_height   = LH_W'(lh);
		h.span_start    = SPAN_W'(s);
		h.span_end      = ROW_W'(e);
		return h;
	endfunction

	// Present one transaction; starts and ends at a falling edge
	task automatic push(logic op, logic [IN_DATA_W-1:0] data);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (tracker.take_item(op, data))
			live_items++;
		@(negedge clk);
	endtask

	task automatic push_pixels(int n);
		repeat (n) push(OP_PIXEL, noise_bits());
	endtask

	// Hold off the sender until nothing is owed, then let a setup finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (tracker.outstanding() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_height(logic [SCR_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_wdata <= h;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tracker.set_height(h);
		@(negedge clk);
	endtask

	// One column: a setup with random content and its pixel items
	task automatic random_column();
		ray_hit_t h;
		int       len, npix, pick;
		h = noise_bits();
		h.pad = '0;
		h.span_end = '0;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			h.line_height = LH_W'($urandom_range(1, 64));
		else if (pick == 1)
			h.line_height = LH_W'($urandom_range(1, 1000));
		else if (pick == 2)
			h.line_height = LH_W'($urandom_range(0, 65535));
		if ($urandom_range(0, 15) == 0)
			h.dir_x = '0;
		if ($urandom_range(0, 15) == 0)
			h.dir_y = '0;
		if ($urandom_range(0, 3) == 0)
			h.wall_distance = DIST_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 80)
			len = $urandom_range(0, 12);
		else if (pick < 95)
			len = $urandom_range(0, 100);
		else
			len = -1;
		if (len < 0) begin
			// arbitrary end, possibly before the start
			h.span_end = ROW_W'($urandom_range(0, 4096));
			npix = $urandom_range(0, 20);
		end else begin
			if (h.span_start + len > 4096)
				h.span_start = SPAN_W'(4096 - len);
			h.span_end = ROW_W'(h.span_start + len);
			npix = len + $urandom_range(0, 2);
		end
		// broken sequence now and then: cut the pixels short or add strays
		pick = $urandom_range(0, 9);
		if (pick == 0)
			npix = $urandom_range(0, npix);
		push(OP_SETUP, h);
		push_pixels(npix);
		if (pick == 1)
			push_pixels($urandom_range(1, 3));
	endtask

	initial begin
		logic [SCR_W-1:0] heights[6];
		int               blk;
		heights[0] = 12'd1;
		heights[1] = 12'd4095;
		heights[2] = SCR_W'($urandom_range(1, 4095));
		heights[3] = 12'd4095;
		heights[4] = 12'd1;
		heights[5] = SCR_W'($urandom_range(1, 4095));
		live_items = 0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset screen height
		push(OP_PIXEL, noise_bits());
		// east wall, mirrored column, negative start position
		push(OP_SETUP, make_hit(0, 0, 24'h012345, 24'h03A000, 18'h0C000, 18'h02000,
			24'h020000, 100, 10, 13));
		push_pixels(4);
		// west wall, all extremes, span reaching row 4096
		push(OP_SETUP, make_hit(4095, 0, 24'hFFFFFF, 24'hFFFFFF, -131072, -131072,
			24'hFFFFFF, 1, 4093, 4096));
		push_pixels(3);
		// south wall, tallest slice
		push(OP_SETUP, make_hit(2049, 1, 24'h7FFFFF, 24'h000000, 131071, 131071,
			24'h000001, 65535, 0, 2));
		push_pixels(2);
		// north wall, mirrored, zero line height
		push(OP_SETUP, make_hit(1, 1, 24'h00FFFF, 24'h800000, 18'h10000, -65536,
			24'h008000, 0, 479, 481));
		push_pixels(2);
		// zero direction on an x side selects north; empty span
		push(OP_SETUP, make_hit(123, 0, 24'h100000, 24'h123456, 0, 18'h08000,
			24'h000000, 480, 200, 100));
		push_pixels(1);
		drain();

		// Random part, several screen heights over three idling patterns
		for (blk = 0; blk < 6; blk++) begin
			if (blk == 2) begin
				send_idle = 71;
				recv_idle = 18;
			end else if (blk == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_height(heights[blk]);
			live_items = 0;
			while (live_items < 300)
				random_column();
			drain();
		end

		if (tracker.outstanding() != 0) begin
			$error("%0d expected output transactions never arrived", tracker.outstanding());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rwtc_pkg.sv
rtl/core/rwtc_div.sv
rtl/core/rwtc_dp.sv
rtl/core/rwtc_ctrl.sv
rtl/core/raycast_wall_texture_column.sv
sim/tb_top.sv
